// ----- sv/rmms_pkg.sv -----
// shared types, constants and helpers for the range max/min spread tree
package rmms_pkg;

    localparam int LEAVES_DEF  = 1024;
    localparam int FIELD_IDX_W = 10;
    localparam int VALUE_W     = 18;
    localparam int SPREAD_W    = 19;

    // func field codes
    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_ASSIGN = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] hi;
        logic signed [VALUE_W-1:0] lo;
    } node_t;

    // accumulator start for a span that holds no leaf
    localparam logic signed [VALUE_W-1:0] EMPTY_MAX = -18'sd100001;
    localparam logic signed [VALUE_W-1:0] EMPTY_MIN = 18'sd100001;
    localparam node_t EMPTY_NODE = '{hi: EMPTY_MAX, lo: EMPTY_MIN};

    typedef struct packed {
        logic  valid;
        node_t span;
    } span_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_READ,
        ST_A_MERGE,
        ST_Q_LEFT,
        ST_Q_RIGHT
    } state_t;

    function automatic node_t node_merge(input node_t a, input node_t b);
        node_t r;
        r = a;
        if (b.hi > a.hi) begin
            r.hi = b.hi;
        end
        if (b.lo < a.lo) begin
            r.lo = b.lo;
        end
        return r;
    endfunction

endpackage

// ----- sv/rmms_ram.sv -----
// generic single write port, single read port ram with registered read
module rmms_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/rmms_ctrl.sv -----
// sequencer that walks the node ram for assign and query items
module rmms_ctrl #(
    parameter int LEAVES = rmms_pkg::LEAVES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic [rmms_pkg::FIELD_IDX_W-1:0]     s_first_index,
    input  logic [rmms_pkg::FIELD_IDX_W-1:0]     s_last_index,
    input  logic [rmms_pkg::FIELD_IDX_W-1:0]     s_position,
    input  logic signed [rmms_pkg::VALUE_W-1:0]  s_new_value,
    input  logic                                 out_free,
    output rmms_pkg::span_result_t               result,
    output logic                                 mem_we,
    output logic [$clog2(2*LEAVES)-1:0]          mem_waddr,
    output rmms_pkg::node_t                      mem_wdata,
    output logic [$clog2(2*LEAVES)-1:0]          mem_raddr,
    input  rmms_pkg::node_t                      mem_rdata
);

    localparam int NW = $clog2(2*LEAVES);
    localparam int RW = NW + 1;
    localparam int LW = $clog2(LEAVES);
    localparam int CW = (LW > rmms_pkg::FIELD_IDX_W) ? LW : rmms_pkg::FIELD_IDX_W;

    rmms_pkg::state_t state_reg, state_next;
    logic [NW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [RW-1:0]    l_reg, l_next;
    logic [RW-1:0]    r_reg, r_next;
    rmms_pkg::node_t  held_reg, held_next;
    rmms_pkg::node_t  acc_reg, acc_next;
    logic             pend_reg, pend_next;

    rmms_pkg::node_t  acc_m;
    rmms_pkg::node_t  held_m;
    logic [LW-1:0]    leaf_a, leaf_f, leaf_l;
    logic [RW-1:0]    r_dec;

    function automatic logic [LW-1:0] clamp_leaf(
        input logic [rmms_pkg::FIELD_IDX_W-1:0] v
    );
        logic [CW-1:0] w;
        w = CW'(v);
        if (w > CW'(LEAVES - 1)) begin
            return LW'(LEAVES - 1);
        end
        return LW'(w);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rmms_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        held_reg <= held_next;
        acc_reg  <= acc_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        held_next    = held_reg;
        acc_next     = acc_reg;
        pend_next    = 1'b0;
        s_ready      = 1'b0;
        result       = '{valid: 1'b0, span: acc_reg};
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        leaf_a = clamp_leaf(s_position);
        leaf_f = clamp_leaf(s_first_index);
        leaf_l = clamp_leaf(s_last_index);
        acc_m  = pend_reg ? rmms_pkg::node_merge(acc_reg, mem_rdata) : acc_reg;
        held_m = rmms_pkg::node_merge(held_reg, mem_rdata);
        r_dec  = r_reg - RW'(1);

        unique case (state_reg)
            rmms_pkg::ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + NW'(1);
                if (clr_cnt_reg == NW'(2*LEAVES - 1)) begin
                    state_next = rmms_pkg::ST_IDLE;
                end
            end
            rmms_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == rmms_pkg::FUNC_ASSIGN) begin
                        // write the leaf now, then refresh ancestors
                        cur_next   = NW'(leaf_a) + NW'(LEAVES);
                        held_next  = '{hi: s_new_value, lo: s_new_value};
                        mem_we     = 1'b1;
                        mem_waddr  = cur_next;
                        mem_wdata  = held_next;
                        state_next = rmms_pkg::ST_A_READ;
                    end else begin
                        l_next = RW'(leaf_f) + RW'(LEAVES);
                        if (leaf_f > leaf_l) begin
                            r_next = l_next;
                        end else begin
                            r_next = RW'(leaf_l) + RW'(LEAVES) + RW'(1);
                        end
                        acc_next   = rmms_pkg::EMPTY_NODE;
                        state_next = rmms_pkg::ST_Q_LEFT;
                    end
                end
            end
            rmms_pkg::ST_A_READ: begin
                if (cur_reg == NW'(1)) begin
                    state_next = rmms_pkg::ST_IDLE;
                end else begin
                    mem_raddr  = cur_reg ^ NW'(1);
                    state_next = rmms_pkg::ST_A_MERGE;
                end
            end
            rmms_pkg::ST_A_MERGE: begin
                held_next  = held_m;
                cur_next   = cur_reg >> 1;
                mem_we     = 1'b1;
                mem_waddr  = cur_next;
                mem_wdata  = held_m;
                state_next = rmms_pkg::ST_A_READ;
            end
            rmms_pkg::ST_Q_LEFT: begin
                acc_next = acc_m;
                if (l_reg >= r_reg) begin
                    // hold the answer until the output register is free
                    if (out_free) begin
                        result     = '{valid: 1'b1, span: acc_m};
                        state_next = rmms_pkg::ST_IDLE;
                    end
                end else begin
                    if (l_reg[0]) begin
                        mem_raddr = l_reg[NW-1:0];
                        pend_next = 1'b1;
                        l_next    = l_reg + RW'(1);
                    end
                    state_next = rmms_pkg::ST_Q_RIGHT;
                end
            end
            rmms_pkg::ST_Q_RIGHT: begin
                acc_next = acc_m;
                l_next   = l_reg >> 1;
                if (r_reg[0]) begin
                    mem_raddr = r_dec[NW-1:0];
                    pend_next = 1'b1;
                    r_next    = r_dec >> 1;
                end else begin
                    r_next = r_reg >> 1;
                end
                state_next = rmms_pkg::ST_Q_LEFT;
            end
            default: begin
                state_next = rmms_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmms_pkg::ST_Q_LEFT) |-> (l_reg <= r_reg))
        else $error("query bounds crossed");

    a_walk_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmms_pkg::ST_A_READ) |-> (cur_reg != '0))
        else $error("ancestor walk passed the root");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == rmms_pkg::ST_CLEAR || state_reg == rmms_pkg::ST_IDLE
                    || state_reg == rmms_pkg::ST_A_MERGE))
        else $error("node write outside clear or assign");

    a_result_room: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> (out_free && $past(state_reg) != rmms_pkg::ST_CLEAR))
        else $error("result issued with output register busy");
`endif

endmodule

// ----- sv/range_max_min_spread_tree.sv -----
// top level of the range max/min spread segment tree
// assign item: the leaf is written, then each ancestor up to the root is rewritten from its sibling
// query item: span walk from the leaves upward, up to two ram reads per level
// rate is set by the single read port of the node ram; one item in flight at a time
// after reset a clearing pass writes all 2*LEAVES nodes to zero, s_ready low meanwhile
// aresetn is synchronous, active low; results leave through a registered output stage
module range_max_min_spread_tree #(
    parameter int LEAVES = rmms_pkg::LEAVES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [rmms_pkg::FIELD_IDX_W-1:0]    s_first_index,
    input  logic [rmms_pkg::FIELD_IDX_W-1:0]    s_last_index,
    input  logic [rmms_pkg::FIELD_IDX_W-1:0]    s_position,
    input  logic signed [rmms_pkg::VALUE_W-1:0] s_new_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rmms_pkg::SPREAD_W-1:0] m_spread
);

    localparam int NW = $clog2(2*LEAVES);

    rmms_pkg::span_result_t result;
    rmms_pkg::node_t        mem_wdata;
    rmms_pkg::node_t        mem_rdata;
    logic                   mem_we;
    logic [NW-1:0]          mem_waddr;
    logic [NW-1:0]          mem_raddr;
    logic                   out_free;

    logic                                 m_valid_reg, m_valid_next;
    logic [rmms_pkg::SPREAD_W-1:0]        m_spread_reg, m_spread_next;

    // node store: one word per tree node, max and min side by side
    rmms_ram #(
        .WIDTH ($bits(rmms_pkg::node_t)),
        .DEPTH (2*LEAVES)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // sequencer: clearing pass, ancestor refresh and span walk
    rmms_ctrl #(
        .LEAVES (LEAVES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_first_index (s_first_index),
        .s_last_index  (s_last_index),
        .s_position    (s_position),
        .s_new_value   (s_new_value),
        .out_free      (out_free),
        .result        (result),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    // output stage free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_spread_next = m_spread_reg;
        if (result.valid) begin
            // sign-extend both to 19 bits, empty span gives -200002
            m_valid_next  = 1'b1;
            m_spread_next = {result.span.hi[rmms_pkg::VALUE_W-1], result.span.hi}
                          - {result.span.lo[rmms_pkg::VALUE_W-1], result.span.lo};
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_spread_reg <= m_spread_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_spread = m_spread_reg;

endmodule
